>>> rtl/assert_macros.svh
// assertion helpers used by clre_tok_buf
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CLRE_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define CLRE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

>>> rtl/clre_pkg.sv
// ----------------------------------------------------------------------------
// clre_pkg
// Types and constants for the cell list run-length encoder.
// ----------------------------------------------------------------------------
package clre_pkg;

  localparam int COORD_BITS = 16;
  localparam int RUN_BITS   = COORD_BITS + 1;
  localparam int MAX_TOKS   = 3;

  // request kinds
  localparam logic REQ_CELL   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // token symbols
  localparam logic [1:0] SYM_LIVE  = 2'd0;
  localparam logic [1:0] SYM_ROW   = 2'd1;
  localparam logic [1:0] SYM_BLANK = 2'd2;
  localparam logic [1:0] SYM_ERROR = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] cell_col;
    logic [COORD_BITS-1:0] cell_row;
  } in_req_t;

  typedef struct packed {
    logic [RUN_BITS-1:0] run_length;
    logic [1:0]          symbol;
    logic                last_token;
  } out_tok_t;

  // tokens produced by one request, slot 0 goes out first
  typedef struct packed {
    out_tok_t [MAX_TOKS-1:0] tok;
    logic [1:0]              cnt;
  } tok_set_t;

endpackage

>>> rtl/clre_enc.sv
// ----------------------------------------------------------------------------
// clre_enc
// Encoder state (row, last column, open run) and token generation for one
// request.
// ----------------------------------------------------------------------------
module clre_enc import clre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_req_t  req,
  output tok_set_t toks
);

  logic [COORD_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [RUN_BITS-1:0]   last_col_r, last_col_nxt;
  logic [RUN_BITS-1:0]   open_run_r, open_run_nxt;

  logic                  fresh, col_none, behind, col_bad, err;
  logic                  run_nz, gap_nz, live_first;
  logic [RUN_BITS-1:0]   col_ext, eff_run, gap, row_diff;
  logic [1:0]            n;

  assign col_ext  = {1'b0, req.cell_col};
  assign fresh    = req.cell_row > cur_row_r;
  assign behind   = req.cell_row < cur_row_r;
  assign col_none = last_col_r == {RUN_BITS{1'b1}};
  assign col_bad  = !fresh && !col_none && (col_ext <= last_col_r);
  assign err      = behind || col_bad;
  assign run_nz   = open_run_r != '0;
  assign eff_run  = fresh ? '0 : open_run_r;
  assign gap      = (fresh || col_none) ? col_ext
                                        : (col_ext - last_col_r - RUN_BITS'(1));
  assign gap_nz   = gap != '0;
  assign row_diff = {1'b0, req.cell_row - cur_row_r};
  // open run is flushed on a new row, or ahead of a blank run
  assign live_first = run_nz && (fresh || gap_nz);

  always_comb begin
    toks.tok = '0;
    n        = 2'd0;
    if (req.req_type == REQ_FINISH) begin
      if (run_nz) begin
        toks.tok[n] = '{run_length: open_run_r, symbol: SYM_LIVE, last_token: 1'b0};
        n = n + 2'd1;
      end
    end else if (err) begin
      toks.tok[n] = '{run_length: RUN_BITS'(1), symbol: SYM_ERROR, last_token: 1'b0};
      n = n + 2'd1;
    end else begin
      if (live_first) begin
        toks.tok[n] = '{run_length: open_run_r, symbol: SYM_LIVE, last_token: 1'b0};
        n = n + 2'd1;
      end
      if (fresh) begin
        toks.tok[n] = '{run_length: row_diff, symbol: SYM_ROW, last_token: 1'b0};
        n = n + 2'd1;
      end
      if (gap_nz) begin
        toks.tok[n] = '{run_length: gap, symbol: SYM_BLANK, last_token: 1'b0};
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      toks.tok[n - 2'd1].last_token = 1'b1;
    end
    toks.cnt = n;
  end

  always_comb begin
    cur_row_nxt  = cur_row_r;
    last_col_nxt = last_col_r;
    open_run_nxt = open_run_r;
    if (take) begin
      if (req.req_type == REQ_FINISH) begin
        cur_row_nxt  = '0;
        last_col_nxt = '1;
        open_run_nxt = '0;
      end else if (!err) begin
        if (fresh) begin
          cur_row_nxt = req.cell_row;
        end
        last_col_nxt = col_ext;
        open_run_nxt = gap_nz ? RUN_BITS'(1) : (eff_run + RUN_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      last_col_r <= '1;
      open_run_r <= '0;
    end else begin
      cur_row_r  <= cur_row_nxt;
      last_col_r <= last_col_nxt;
      open_run_r <= open_run_nxt;
    end
  end

endmodule

>>> rtl/clre_tok_buf.sv
// ----------------------------------------------------------------------------
// clre_tok_buf
// Holds the tokens of one request and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clre_tok_buf import clre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  tok_set_t toks,
  output logic     buf_free,
  output logic     out_valid,
  input  logic     out_stall,
  output out_tok_t out_data
);

  out_tok_t [MAX_TOKS-1:0] tok_r, tok_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic                    out_fire;

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = tok_r[idx_r];
  assign out_fire  = out_valid && !out_stall;
  // free when empty, or once the last held token leaves this cycle
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !out_stall);

  always_comb begin
    tok_nxt = tok_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      tok_nxt = toks.tok;
      cnt_nxt = toks.cnt;
      idx_nxt = 2'd0;
    end else if (out_fire) begin
      cnt_nxt = cnt_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  `CLRE_ASSERT_IMP(a_last_on_final, clk, rst_n, out_valid,
                   out_data.last_token == (cnt_r == 2'd1))
  `CLRE_ASSERT_IMP(a_slots_in_range, clk, rst_n, out_valid,
                   ({1'b0, idx_r} + {1'b0, cnt_r}) <= 3'd3)
  `CLRE_ASSERT_IMP(a_error_single, clk, rst_n,
                   out_valid && (out_data.symbol == SYM_ERROR),
                   (out_data.run_length == RUN_BITS'(1)) && out_data.last_token)
  `CLRE_ASSERT_NEXT(a_drain_empty, clk, rst_n,
                    out_fire && (cnt_r == 2'd1) && !load, !out_valid)

endmodule

>>> rtl/cell_list_rle_encoder_unit.sv
// a request passes the staging register, then the token buffer, which drives out_
// throughput: one request per cycle with out_stall low and each making at most one token
// requests behind one that causes more than one token stall while the token buffer drains
// reset clears row, column and open run state and both pipeline valids
// no clearing pass; the block takes requests in the first cycle after reset
// ----------------------------------------------------------------------------
// cell_list_rle_encoder_unit
// Turns a sorted list of live cells into run-length tokens.
// ----------------------------------------------------------------------------
module cell_list_rle_encoder_unit import clre_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_tok_t out_data
);

  logic     stg_valid_r, stg_valid_nxt;
  in_req_t  stg_data_r, stg_data_nxt;
  logic     buf_free, move, in_fire;
  tok_set_t toks;

  assign move     = stg_valid_r && buf_free;
  assign in_stall = stg_valid_r && !buf_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    stg_data_nxt  = stg_data_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
      stg_data_nxt  = in_data;
    end else if (move) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stg_data_r <= stg_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  clre_enc u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (move),
    .req   (stg_data_r),
    .toks  (toks)
  );

  clre_tok_buf u_tok_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move),
    .toks      (toks),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> test/tb_cell_list_rle_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cell_list_rle_encoder_unit
// Feeds sorted live-cell lists, stray finishes and out-of-order cells into the
// encoder, predicts every token it should emit and checks each token field by
// field under random idling on both sides, and in a last pass with none.
// ----------------------------------------------------------------------------
module tb_cell_list_rle_encoder_unit;
  import clre_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam logic [RUN_BITS-1:0] COL_NONE = '1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_tok_t out_data;

  int send_idle_pct = 34;
  int recv_stall_pct = 88;
  int fail_count = 0;
  int quiet_cycles = 0;

  // encoder state as the tokens imply it
  logic [COORD_BITS-1:0] row_now;
  logic [RUN_BITS-1:0]   col_last;
  logic [RUN_BITS-1:0]   run_open;
  out_tok_t              pending_tokens[$];

  cell_list_rle_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_tok_t make_token(logic [RUN_BITS-1:0] len, logic [1:0] sym);
    out_tok_t t;
    t.run_length = len;
    t.symbol     = sym;
    t.last_token = 1'b0;
    return t;
  endfunction

  function automatic void clear_encoder_state();
    row_now  = '0;
    col_last = COL_NONE;
    run_open = '0;
  endfunction

  // work out the tokens one accepted request causes and queue them
  function automatic void encode_request(in_req_t req);
    out_tok_t            toks[$];
    logic [RUN_BITS-1:0] gap;
    logic                fresh_row;
    logic                col_none;
    if (req.req_type == REQ_FINISH) begin
      if (run_open != 0) toks = {toks, make_token(run_open, SYM_LIVE)};
      clear_encoder_state();
    end else begin
      fresh_row = req.cell_row > row_now;
      col_none  = (col_last == COL_NONE);
      if (req.cell_row < row_now ||
          (!fresh_row && !col_none && {1'b0, req.cell_col} <= col_last)) begin
        toks = {toks, make_token(RUN_BITS'(1), SYM_ERROR)};
      end else begin
        if (fresh_row) begin
          if (run_open != 0) begin
            toks = {toks, make_token(run_open, SYM_LIVE)};
            run_open = '0;
          end
          toks = {toks, make_token({1'b0, req.cell_row - row_now}, SYM_ROW)};
          row_now  = req.cell_row;
          col_last = COL_NONE;
          col_none = 1'b1;
        end
        gap = col_none ? {1'b0, req.cell_col} : {1'b0, req.cell_col} - col_last - 1'b1;
        if (gap == 0) begin
          run_open = run_open + 1'b1;
        end else begin
          if (run_open != 0) toks = {toks, make_token(run_open, SYM_LIVE)};
          toks = {toks, make_token(gap, SYM_BLANK)};
          run_open = RUN_BITS'(1);
        end
        col_last = {1'b0, req.cell_col};
      end
    end
    if (toks.size() > 0) toks[toks.size()-1].last_token = 1'b1;
    pending_tokens = {pending_tokens, toks};
  endfunction

  // a cell that keeps the list in order, from the current encoder state, or a finish when no such cell is left
  function automatic in_req_t pick_next_cell();
    in_req_t     r;
    int unsigned k;
    int unsigned step;
    int unsigned room;
    int unsigned base;
    logic        same_ok;
    logic        adv_ok;
    r = '0;
    r.req_type = REQ_CELL;
    same_ok = (col_last == COL_NONE) || (col_last < COORD_MAX);
    adv_ok  = (row_now != COORD_MAX);
    k = $urandom_range(0, 9);
    if (!same_ok && !adv_ok) begin
      r.req_type = REQ_FINISH;
    end else if (adv_ok && (!same_ok || $urandom_range(0, 99) < 25)) begin
      room = COORD_MAX - row_now;
      if (k < 7) step = 1;
      else if (k < 9) step = $urandom_range(2, 4);
      else step = $urandom_range(1, room);
      if (step > room) step = room;
      r.cell_row = COORD_BITS'(row_now + step);
      k = $urandom_range(0, 9);
      if (k < 6) r.cell_col = '0;
      else if (k < 9) r.cell_col = COORD_BITS'($urandom_range(1, 5));
      else r.cell_col = COORD_BITS'($urandom_range(0, COORD_MAX));
    end else begin
      base = (col_last == COL_NONE) ? 0 : col_last + 1;
      room = COORD_MAX - base;
      if (k < 5) step = 0;
      else if (k < 9) step = $urandom_range(1, 6);
      else step = $urandom_range(0, room);
      if (step > room) step = room;
      r.cell_row = row_now;
      r.cell_col = COORD_BITS'(base + step);
    end
    return r;
  endfunction

  // random cells, repeated columns, rows going back and stray finishes
  function automatic in_req_t pick_noise_req();
    in_req_t r;
    r.req_type = REQ_CELL;
    r.cell_col = COORD_BITS'($urandom_range(0, COORD_MAX));
    r.cell_row = COORD_BITS'($urandom_range(0, COORD_MAX));
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        r.cell_row = row_now;
        if (col_last != COL_NONE) r.cell_col = col_last[COORD_BITS-1:0];
      end
      2: if (row_now != 0) r.cell_row = COORD_BITS'($urandom_range(0, row_now - 1));
      default: r.req_type = REQ_FINISH;
    endcase
    return r;
  endfunction

  task automatic send_request(input in_req_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    encode_request(req);
  endtask

  task automatic send_cell(input int unsigned col, input int unsigned row);
    in_req_t r;
    r.req_type = REQ_CELL;
    r.cell_col = COORD_BITS'(col);
    r.cell_row = COORD_BITS'(row);
    send_request(r);
  endtask

  task automatic send_finish(input int unsigned col, input int unsigned row);
    in_req_t r;
    r.req_type = REQ_FINISH;
    r.cell_col = COORD_BITS'(col);
    r.cell_row = COORD_BITS'(row);
    send_request(r);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_finish();
    send_finish(COORD_MAX, COORD_MAX);
    send_finish(0, 0);
  endtask

  task automatic test_single_row_runs();
    send_cell(3, 0);
    send_cell(4, 0);
    send_cell(5, 0);
    send_cell(9, 0);
    send_finish(0, 0);
  endtask

  task automatic test_row_advance();
    send_cell(0, 0);
    send_cell(1, 0);
    send_cell(0, 2);
    // open run, row advance and blank run from one cell
    send_cell(6, 5);
    send_finish(0, 0);
  endtask

  task automatic test_order_errors();
    send_cell(4, 1);
    send_cell(4, 1);
    send_cell(2, 1);
    send_cell(9, 0);
    send_cell(5, 1);
    send_finish(0, 0);
  endtask

  task automatic test_coordinate_extremes();
    send_cell(COORD_MAX, COORD_MAX);
    send_cell(COORD_MAX, COORD_MAX);
    send_cell(0, 0);
    send_finish(0, 0);
    send_cell(0, 0);
    send_cell(COORD_MAX, 0);
    send_cell(16'h5555, 16'hAAAA);
    send_finish(16'h5555, 16'hAAAA);
  endtask

  task automatic test_random_streams(input int n_items);
    int      sent;
    int      stream_len;
    in_req_t req;
    sent = 0;
    while (sent < n_items) begin
      stream_len = $urandom_range(3, 30);
      for (int i = 0; i < stream_len && sent < n_items; i++) begin
        if ($urandom_range(0, 99) < 12) req = pick_noise_req();
        else req = pick_next_cell();
        send_request(req);
        sent++;
      end
      // some lists run on into the next without a finish
      if ($urandom_range(0, 99) < 85) begin
        send_finish($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_tok_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: symbol %0d run_length %0d last_token %0d",
               out_data.symbol, out_data.run_length, out_data.last_token);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (out_data.run_length !== want.run_length) begin
          $error("run_length: expected %0d, got %0d", want.run_length, out_data.run_length);
          fail_count++;
        end
        if (out_data.symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, out_data.symbol);
          fail_count++;
        end
        if (out_data.last_token !== want.last_token) begin
          $error("last_token: expected %0d, got %0d", want.last_token, out_data.last_token);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cell_list_rle_encoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    clear_encoder_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_finish();
    test_single_row_runs();
    test_row_advance();
    test_order_errors();
    test_coordinate_extremes();
    test_random_streams(90);
    wait_for_drain();

    send_idle_pct  = 88;
    recv_stall_pct = 34;
    test_random_streams(90);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_streams(74);
    wait_for_drain();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("cell_list_rle_encoder_unit verification clean");
    end else begin
      $display("cell_list_rle_encoder_unit verification failed");
    end
    $finish;
  end

endmodule
